[hw/rtl/tpeq_pkg.sv]
`default_nettype none

package tpeq_pkg;

    // One queued pin write.
    typedef struct packed {
        logic [31:0] due_time;
        logic [7:0]  kind_code;
        logic [7:0]  pin;
        logic [7:0]  level;
    } entry_t;

    // Per-cell controls from the sequencer.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_CLEAR    = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        RK_FIRED     = 3'd0,
        RK_SCHEDULED = 3'd1,
        RK_FULL      = 3'd2,
        RK_CLEARED   = 3'd3,
        RK_NONE_DUE  = 3'd4
    } result_kind_t;

    typedef enum logic [1:0] {
        WK_DIGITAL = 2'd0,
        WK_ANALOG  = 2'd1,
        WK_UNKNOWN = 2'd2
    } write_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    localparam logic CFG_DIGITAL_KIND = 1'b0;
    localparam logic CFG_ANALOG_KIND  = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/tpeq_cell.sv]
`default_nettype none

module tpeq_cell (
    input  wire logic                clk,
    input  wire tpeq_pkg::cell_ctrl_t ctrl,
    input  wire tpeq_pkg::entry_t    right_entry,
    input  wire tpeq_pkg::entry_t    load_entry,
    output tpeq_pkg::entry_t         entry
);
    import tpeq_pkg::*;

    entry_t entry_reg;

    // A load wins over the shift: the kept entry lands behind the shifted ones.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[hw/rtl/timed_pin_event_queue_unit.sv]
`default_nettype none

// Timed pin event queue. The queue is a row of DEPTH cells in schedule order,
// cell 0 at the head. Schedule and clear each give a single result, which
// shows in the cycle after the transfer while busy stays low. An unused action
// gives no result. A tick keeps busy high while it scans, and the number of
// held entries sets how long the scan lasts and so when busy falls. Each cycle
// the head entry is examined while the row shifts one place toward the head,
// and a not-yet-due entry is written back behind the entries still to examine,
// so the survivors end up compacted in order. Fired results come out at most
// one per cycle; each is held back until the next due entry is found or the
// scan ends, so that the final one can carry last. The final result of a tick
// shows in the cycle in which busy falls. The receiver cannot stall, so every
// strobed result must be taken in its cycle.
module timed_pin_event_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] event_time,
    input  wire logic [7:0]  write_kind_code,
    input  wire logic [7:0]  pin,
    input  wire logic [7:0]  level,
    input  wire logic [31:0] tick_time,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             result_valid,
    output logic [2:0]       result_kind,
    output logic [7:0]       out_pin,
    output logic [7:0]       out_level,
    output logic [1:0]       write_kind,
    output logic [4:0]       executed_count,
    output logic             last
);
    import tpeq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    state_t       state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [31:0]  now_reg, now_next;
    logic [4:0]   done_reg, done_next;
    logic [7:0]   digital_reg, analog_reg;

    logic         pend_valid_reg, pend_valid_next;
    logic [7:0]   pend_pin_reg, pend_pin_next;
    logic [7:0]   pend_level_reg, pend_level_next;
    write_kind_t  pend_wk_reg, pend_wk_next;
    logic [4:0]   pend_cnt_reg, pend_cnt_next;

    logic         res_valid_reg, res_valid_next;
    result_kind_t res_kind_reg, res_kind_next;
    logic [7:0]   res_pin_reg, res_pin_next;
    logic [7:0]   res_level_reg, res_level_next;
    write_kind_t  res_wk_reg, res_wk_next;
    logic [4:0]   res_cnt_reg, res_cnt_next;
    logic         res_last_reg, res_last_next;

    logic         sched_load;
    logic         keep_load;
    logic         scan_shift;
    logic [CW-1:0] wpos_full;
    logic [IW-1:0] wpos;
    logic [IW-1:0] tail;
    logic         due;
    write_kind_t  head_wk;
    entry_t       in_entry;
    entry_t       load_entry;
    entry_t       cells [DEPTH];
    cell_ctrl_t   ctrl [DEPTH];

    assign in_entry = '{due_time: event_time, kind_code: write_kind_code,
                        pin: pin, level: level};
    assign load_entry = sched_load ? in_entry : cells[0];

    // Kept entries go right behind the entries still waiting to be examined.
    assign wpos_full = rem_reg - CW'(1) + kept_reg;
    assign wpos = wpos_full[IW-1:0];
    assign tail = count_reg[IW-1:0];

    assign due = now_reg >= cells[0].due_time;

    always_comb
    begin
        if (cells[0].kind_code == digital_reg)
        begin
            head_wk = WK_DIGITAL;
        end
        else if (cells[0].kind_code == analog_reg)
        begin
            head_wk = WK_ANALOG;
        end
        else
        begin
            head_wk = WK_UNKNOWN;
        end
    end

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            assign ctrl[j].shift = scan_shift;
            assign ctrl[j].load  = (sched_load && tail == IW'(j))
                                || (keep_load && wpos == IW'(j));
            tpeq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[j]),
                .right_entry (cells[(j + 1) % DEPTH]),
                .load_entry  (load_entry),
                .entry       (cells[j])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rem_reg        <= '0;
            kept_reg       <= '0;
            done_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            digital_reg    <= 8'd0;
            analog_reg     <= 8'd1;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
            kept_reg       <= kept_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIGITAL_KIND: digital_reg <= cfg_data;
                    CFG_ANALOG_KIND:  analog_reg  <= cfg_data;
                    default:          digital_reg <= digital_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        pend_pin_reg   <= pend_pin_next;
        pend_level_reg <= pend_level_next;
        pend_wk_reg    <= pend_wk_next;
        pend_cnt_reg   <= pend_cnt_next;
        res_kind_reg   <= res_kind_next;
        res_pin_reg    <= res_pin_next;
        res_level_reg  <= res_level_next;
        res_wk_reg     <= res_wk_next;
        res_cnt_reg    <= res_cnt_next;
        res_last_reg   <= res_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        kept_next       = kept_reg;
        now_next        = now_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_pin_next   = pend_pin_reg;
        pend_level_next = pend_level_reg;
        pend_wk_next    = pend_wk_reg;
        pend_cnt_next   = pend_cnt_reg;
        res_valid_next  = 1'b0;
        res_kind_next   = RK_NONE_DUE;
        res_pin_next    = 8'd0;
        res_level_next  = 8'd0;
        res_wk_next     = WK_DIGITAL;
        res_cnt_next    = 5'd0;
        res_last_next   = 1'b1;
        sched_load      = 1'b0;
        keep_load       = 1'b0;
        scan_shift      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_SCHEDULE:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                res_kind_next = RK_FULL;
                            end
                            else
                            begin
                                sched_load    = 1'b1;
                                count_next    = count_reg + CW'(1);
                                res_kind_next = RK_SCHEDULED;
                            end
                        end
                        ACT_TICK:
                        begin
                            now_next        = tick_time;
                            rem_next        = count_reg;
                            kept_next       = '0;
                            done_next       = 5'd0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        ACT_CLEAR:
                        begin
                            count_next     = '0;
                            res_valid_next = 1'b1;
                            res_kind_next  = RK_CLEARED;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    res_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_kind_next  = RK_FIRED;
                        res_pin_next   = pend_pin_reg;
                        res_level_next = pend_level_reg;
                        res_wk_next    = pend_wk_reg;
                        res_cnt_next   = pend_cnt_reg;
                    end
                    else
                    begin
                        res_kind_next = RK_NONE_DUE;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = kept_reg;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    scan_shift = 1'b1;
                    rem_next   = rem_reg - CW'(1);
                    if (due)
                    begin
                        // The previous fired entry is now known not to be the final one.
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = RK_FIRED;
                            res_pin_next   = pend_pin_reg;
                            res_level_next = pend_level_reg;
                            res_wk_next    = pend_wk_reg;
                            res_cnt_next   = pend_cnt_reg;
                            res_last_next  = 1'b0;
                        end
                        done_next       = done_reg + {4'd0, head_wk != WK_UNKNOWN};
                        pend_valid_next = 1'b1;
                        pend_pin_next   = cells[0].pin;
                        pend_level_next = cells[0].level;
                        pend_wk_next    = head_wk;
                        pend_cnt_next   = done_next;
                    end
                    else
                    begin
                        keep_load = 1'b1;
                        kept_next = kept_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = state_reg != ST_IDLE;
    assign result_valid   = res_valid_reg;
    assign result_kind    = res_kind_reg;
    assign out_pin        = res_pin_reg;
    assign out_level      = res_level_reg;
    assign write_kind     = res_wk_reg;
    assign executed_count = res_cnt_reg;
    assign last           = res_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, rem_reg} + {1'b0, kept_reg} <= {1'b0, count_reg}))
        else $error("scan positions overrun the queue");

    a_sched_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_SCHEDULE) |=> result_valid)
        else $error("schedule transfer gave no result");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != RK_FIRED) |-> last)
        else $error("non-fired result without last");

    a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rem_reg == '0) |=> (result_valid && last && !busy))
        else $error("tick ended without a final result");
`endif

endmodule

`default_nettype wire
